@@ sv/overwriting_event_ring_with_lap_detect_macros.svh @@
// assertion macros for the event log ring
// included by the top level; no other dependencies
`ifndef OVERWRITING_EVENT_RING_WITH_LAP_DETECT_MACROS_SVH
`define OVERWRITING_EVENT_RING_WITH_LAP_DETECT_MACROS_SVH

// same-cycle implication, disabled during reset
`define OERLD_ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("oerld assertion failed");

// next-cycle implication, disabled during reset
`define OERLD_ASSERT_NXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("oerld assertion failed");

`endif

@@ sv/oerld_pkg.sv @@
// types and codes shared by the event log ring modules
// no dependencies
`timescale 1ns / 1ps

package oerld_pkg;

  // ring pointer field width carried in commands, enough for rings of up to 4096 entries
  localparam int RING_PTR_W = 12;
  localparam int COUNT_W    = 7;

  typedef enum logic {
    OP_EMIT     = 1'b0,
    OP_SNAPSHOT = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef struct packed {
    opcode_t              opcode;
    logic [15:0]          category;
    logic [7:0]           slot_id;
    logic signed [15:0]   rc;
    logic [63:0]          digest_head;
    logic [63:0]          tick;
    logic [COUNT_W-1:0]   max_entries;
  } in_item_t;

  typedef struct packed {
    kind_t                kind;
    logic [31:0]          entry_seq;
    logic [63:0]          entry_tick;
    logic [63:0]          entry_digest;
    logic [15:0]          entry_category;
    logic signed [15:0]   entry_rc;
    logic [7:0]           entry_slot;
    logic                 overspeed_warn;
    logic [COUNT_W-1:0]   returned_count;
    logic [31:0]          total_count;
    logic                 last;
  } out_item_t;

  // one stored ring entry
  typedef struct packed {
    logic [31:0]          seq;
    logic [63:0]          tick;
    logic [63:0]          digest;
    logic [15:0]          category;
    logic signed [15:0]   rc;
    logic [7:0]           slot;
  } ram_word_t;

  // classified command from the front end to the back end
  typedef struct packed {
    opcode_t                 op;
    logic                    warn;
    logic [COUNT_W-1:0]      count;
    logic [RING_PTR_W-1:0]   pos;
    logic [31:0]             total;
    ram_word_t               entry;
  } cmd_t;

endpackage

@@ sv/overwriting_event_ring_with_lap_detect.sv @@
// overwriting_event_ring_with_lap_detect: top level of the event log ring
// uses oerld_pkg, oerld_front, oerld_cmd_queue, oerld_back, oerld_ram, macros header
// path: each result passes the command queue, the read stage and the output queue
// throughput: one emit per cycle while the queues have room; a snapshot of n entries
//   holds the back end, one entry per cycle through the single ram read port
// reset: synchronous; control state clears, ring contents stay undefined until written
`timescale 1ns / 1ps
`include "overwriting_event_ring_with_lap_detect_macros.svh"

module overwriting_event_ring_with_lap_detect #(
  parameter int RING_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  oerld_pkg::in_item_t  req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output oerld_pkg::out_item_t rsp
);

  localparam int PW = $clog2(RING_DEPTH);
  localparam int RW = $bits(oerld_pkg::ram_word_t);

  logic                 q_full;
  logic                 q_push;
  oerld_pkg::cmd_t      q_cmd;
  logic                 cmd_valid;
  oerld_pkg::cmd_t      cmd;
  logic                 cmd_pop;

  logic                 ram_we;
  logic [PW-1:0]        ram_waddr;
  oerld_pkg::ram_word_t ram_wdata;
  logic                 ram_re;
  logic [PW-1:0]        ram_raddr;
  logic [RW-1:0]        ram_rdata_raw;
  oerld_pkg::ram_word_t ram_rdata;

  assign ram_rdata = oerld_pkg::ram_word_t'(ram_rdata_raw);

  // accept and classify
  oerld_front #(
    .RING_DEPTH (RING_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_stall (req_stall),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  // decoupling queue
  oerld_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .valid    (cmd_valid),
    .head     (cmd),
    .pop      (cmd_pop)
  );

  // execute against the ring
  oerld_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // ring storage: seq, tick, digest and info in one word per entry
  oerld_ram #(
    .WIDTH (RW),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  // checks
  `OERLD_ASSERT_IMP(a_pop_needs_head, clk, rst, cmd_pop, cmd_valid)
  `OERLD_ASSERT_NXT(a_head_holds, clk, rst, cmd_valid && !cmd_pop, cmd_valid && $stable(cmd))
  `OERLD_ASSERT_IMP(a_ack_single, clk, rst, rsp_valid && rsp.kind == oerld_pkg::KIND_ACK, rsp.last && rsp.returned_count == '0)
  `OERLD_ASSERT_IMP(a_warn_on_ack, clk, rst, rsp_valid && rsp.overspeed_warn, rsp.kind == oerld_pkg::KIND_ACK)

endmodule

@@ sv/oerld_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module oerld_ram #(
  parameter int WIDTH = 200,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/oerld_front.sv @@
// front end: accepts transactions, keeps total, drained mark and cooldown,
// and classifies each item into a command; uses oerld_pkg
`timescale 1ns / 1ps

module oerld_front #(
  parameter int RING_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  oerld_pkg::in_item_t req,
  output logic                req_stall,
  input  logic                q_full,
  output logic                q_push,
  output oerld_pkg::cmd_t     q_cmd
);

  localparam int PW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int NW = (CW > oerld_pkg::COUNT_W) ? CW : oerld_pkg::COUNT_W;

  logic [31:0]  total, total_next;
  logic [31:0]  mark, mark_next;
  logic [CW-1:0] cooldown, cooldown_next;
  logic [PW-1:0] wr_pos, wr_pos_next;

  logic                          accept;
  logic [31:0]                   total_inc;
  logic [31:0]                   backlog;
  logic                          lap;
  logic                          warn;
  logic [CW-1:0]                 have;
  logic [NW-1:0]                 n_wide;
  logic [oerld_pkg::COUNT_W-1:0] n;
  logic [PW-1:0]                 start;
  logic [PW-1:0]                 wr_pos_inc;

  assign req_stall = q_full;
  assign accept    = req_valid && !q_full;
  assign q_push    = accept;

  // emit bookkeeping and snapshot sizing
  always_comb begin
    total_inc = total + 32'd1;
    backlog   = total_inc - mark;
    lap       = backlog > 32'(RING_DEPTH);
    warn      = lap && (cooldown == '0);
    have      = (total < 32'(RING_DEPTH)) ? total[CW-1:0] : CW'(RING_DEPTH);
    n_wide    = (NW'(have) < NW'(req.max_entries)) ? NW'(have) : NW'(req.max_entries);
    n         = n_wide[oerld_pkg::COUNT_W-1:0];
    start     = (total >= 32'(RING_DEPTH)) ? wr_pos : '0;
    // write position follows total mod depth, including the 32-bit wrap
    if (total_inc == '0) begin
      wr_pos_inc = '0;
    end else if (wr_pos == PW'(RING_DEPTH - 1)) begin
      wr_pos_inc = '0;
    end else begin
      wr_pos_inc = wr_pos + 1'b1;
    end
  end

  // command build and state update
  always_comb begin
    total_next    = total;
    mark_next     = mark;
    cooldown_next = cooldown;
    wr_pos_next   = wr_pos;
    q_cmd         = '0;
    q_cmd.op      = req.opcode;
    q_cmd.total   = total;
    unique case (req.opcode)
      oerld_pkg::OP_EMIT: begin
        q_cmd.warn           = warn;
        q_cmd.pos            = oerld_pkg::RING_PTR_W'(wr_pos);
        q_cmd.total          = total_inc;
        q_cmd.entry.seq      = total;
        q_cmd.entry.tick     = req.tick;
        q_cmd.entry.digest   = req.digest_head;
        q_cmd.entry.category = req.category;
        q_cmd.entry.rc       = req.rc;
        q_cmd.entry.slot     = req.slot_id;
        if (accept) begin
          total_next  = total_inc;
          wr_pos_next = wr_pos_inc;
          if (lap) begin
            cooldown_next = warn ? CW'(RING_DEPTH) : cooldown - 1'b1;
          end
        end
      end
      oerld_pkg::OP_SNAPSHOT: begin
        q_cmd.count = n;
        q_cmd.pos   = oerld_pkg::RING_PTR_W'(start);
        if (accept && (req.max_entries != '0) && (total > mark)) begin
          mark_next = total;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total    <= '0;
      mark     <= '0;
      cooldown <= '0;
      wr_pos   <= '0;
    end else begin
      total    <= total_next;
      mark     <= mark_next;
      cooldown <= cooldown_next;
      wr_pos   <= wr_pos_next;
    end
  end

endmodule

@@ sv/oerld_cmd_queue.sv @@
// two-entry command queue between front end and back end
// uses oerld_pkg
`timescale 1ns / 1ps

module oerld_cmd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  oerld_pkg::cmd_t push_cmd,
  output logic            full,
  output logic            valid,
  output oerld_pkg::cmd_t head,
  input  logic            pop
);

  oerld_pkg::cmd_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt, cnt_next;

  assign full  = (cnt == 2'd2);
  assign valid = (cnt != 2'd0);
  assign head  = slots[rd_ptr];

  // occupancy
  always_comb begin
    cnt_next = cnt + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt_next;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ sv/oerld_back.sv @@
// back end: writes emits into the ring, streams snapshot entries one per cycle
// when not stalled; results go to a two-entry output queue; uses oerld_pkg
`timescale 1ns / 1ps

module oerld_back #(
  parameter int RING_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  input  oerld_pkg::cmd_t                 cmd,
  output logic                            cmd_pop,
  output logic                            ram_we,
  output logic [$clog2(RING_DEPTH)-1:0]   ram_waddr,
  output oerld_pkg::ram_word_t            ram_wdata,
  output logic                            ram_re,
  output logic [$clog2(RING_DEPTH)-1:0]   ram_raddr,
  input  oerld_pkg::ram_word_t            ram_rdata,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output oerld_pkg::out_item_t            rsp
);

  localparam int PW = $clog2(RING_DEPTH);

  // snapshot walk
  logic [oerld_pkg::COUNT_W-1:0] rd_idx, rd_idx_next;
  logic [PW-1:0]                 rd_pos, rd_pos_next;

  // read stage
  logic                 s1_valid;
  logic                 s1_from_ram;
  oerld_pkg::out_item_t s1_meta;
  oerld_pkg::out_item_t s1_res;

  // output queue
  oerld_pkg::out_item_t obuf [2];
  logic       owr;
  logic       ord;
  logic [1:0] occ, occ_next;

  logic                 out_pop;
  logic [1:0]           occ_left;
  logic                 room;
  logic                 issue;
  logic                 entry_issue;
  logic                 final_issue;
  logic [PW-1:0]        issue_pos;
  oerld_pkg::out_item_t meta;

  assign rsp_valid = (occ != 2'd0);
  assign rsp       = obuf[ord];
  assign out_pop   = rsp_valid && !rsp_stall;

  // issue only when the result will find a free output slot
  always_comb begin
    occ_left = occ - {1'b0, out_pop};
    room     = ({1'b0, occ_left} + {2'b0, s1_valid}) < 3'd2;
    issue    = cmd_valid && room;
  end

  // classify the head command into one result slot
  always_comb begin
    meta        = '0;
    entry_issue = 1'b0;
    final_issue = 1'b1;
    issue_pos   = (rd_idx == '0) ? cmd.pos[PW-1:0] : rd_pos;
    meta.total_count = cmd.total;
    unique case (cmd.op)
      oerld_pkg::OP_EMIT: begin
        meta.kind           = oerld_pkg::KIND_ACK;
        meta.entry_seq      = cmd.entry.seq;
        meta.entry_tick     = cmd.entry.tick;
        meta.entry_digest   = cmd.entry.digest;
        meta.entry_category = cmd.entry.category;
        meta.entry_rc       = cmd.entry.rc;
        meta.entry_slot     = cmd.entry.slot;
        meta.overspeed_warn = cmd.warn;
        meta.last           = 1'b1;
      end
      oerld_pkg::OP_SNAPSHOT: begin
        if (cmd.count == '0) begin
          meta.kind = oerld_pkg::KIND_EMPTY;
          meta.last = 1'b1;
        end else begin
          entry_issue         = 1'b1;
          final_issue         = (rd_idx == cmd.count - 1'b1);
          meta.kind           = oerld_pkg::KIND_ENTRY;
          meta.returned_count = cmd.count;
          meta.last           = final_issue;
        end
      end
      default: ;
    endcase
  end

  assign cmd_pop   = issue && final_issue;
  assign ram_we    = issue && (cmd.op == oerld_pkg::OP_EMIT);
  assign ram_waddr = cmd.pos[PW-1:0];
  assign ram_wdata = cmd.entry;
  assign ram_re    = issue && entry_issue;
  assign ram_raddr = issue_pos;

  // walk counters for multi-entry snapshots
  always_comb begin
    rd_idx_next = rd_idx;
    rd_pos_next = rd_pos;
    if (issue && entry_issue) begin
      rd_idx_next = final_issue ? '0 : rd_idx + 1'b1;
      rd_pos_next = (issue_pos == PW'(RING_DEPTH - 1)) ? '0 : issue_pos + 1'b1;
    end
  end

  // merge ram data into the staged result
  always_comb begin
    s1_res = s1_meta;
    if (s1_from_ram) begin
      s1_res.entry_seq      = ram_rdata.seq;
      s1_res.entry_tick     = ram_rdata.tick;
      s1_res.entry_digest   = ram_rdata.digest;
      s1_res.entry_category = ram_rdata.category;
      s1_res.entry_rc       = ram_rdata.rc;
      s1_res.entry_slot     = ram_rdata.slot;
    end
  end

  always_comb begin
    occ_next = occ + {1'b0, s1_valid} - {1'b0, out_pop};
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx   <= '0;
      rd_pos   <= '0;
      s1_valid <= 1'b0;
      owr      <= 1'b0;
      ord      <= 1'b0;
      occ      <= 2'd0;
    end else begin
      rd_idx   <= rd_idx_next;
      rd_pos   <= rd_pos_next;
      s1_valid <= issue;
      if (s1_valid) begin
        owr <= !owr;
      end
      if (out_pop) begin
        ord <= !ord;
      end
      occ <= occ_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_meta     <= meta;
      s1_from_ram <= entry_issue;
    end
    if (s1_valid) begin
      obuf[owr] <= s1_res;
    end
  end

endmodule
